@@ sv/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the square spiral position core
// Coordinate format, saturation limits and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int COORD_W  = 24;
    localparam int STEP_W   = 16;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [STEP_W-1:0]  t_step;

    // one unit step, 1.0 with 8 fraction bits
    localparam logic signed [COORD_W:0] UNIT_STEP = 25'sd256;
    localparam logic signed [COORD_W:0] COORD_MAX = 25'sd8388607;
    localparam logic signed [COORD_W:0] COORD_MIN = -25'sd8388608;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request, set up the walk
        logic step;   // take one spiral step
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;   // no steps left
    } t_sts;

endpackage

@@ sv/ssp_if.sv @@
// ----------------------------------------------------------------------------
// ssp_in_if / ssp_out_if: valid/ready channels of the spiral core
// Request channel carries the start point and step count, result the position.
// ----------------------------------------------------------------------------
interface ssp_in_if import ssp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord start_z;
    t_step  step_count;

    modport source (output valid, start_x, start_y, start_z, step_count, input ready);
    modport sink   (input valid, start_x, start_y, start_z, step_count, output ready);
endinterface

interface ssp_out_if import ssp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord pos_x;
    t_coord pos_y;
    t_coord pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

@@ sv/ssp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssp_ctrl: request sequencer
// Loads a request, steps the datapath until the count runs out, holds result.
// ----------------------------------------------------------------------------
module ssp_ctrl import ssp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_sts.done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // no request is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_cmd.load  = o_in_ready && i_in_valid;
    assign o_cmd.step  = (r_state == ST_RUN) && !i_sts.done;

endmodule

@@ sv/ssp_dpath.sv @@
// ----------------------------------------------------------------------------
// ssp_dpath: spiral walk datapath
// Position registers, step counter, run length, turn/sign marks, direction.
// ----------------------------------------------------------------------------
module ssp_dpath import ssp_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic   i_clk,
    input  t_cmd   i_cmd,
    input  t_coord i_start_x,
    input  t_coord i_start_y,
    input  t_coord i_start_z,
    input  t_step  i_step_count,
    output t_sts   o_sts,
    output t_coord o_pos_x,
    output t_coord o_pos_y,
    output t_coord o_pos_z
);

    // bits of the count actually used
    localparam int NW = (COUNT_BITS < STEP_W) ? COUNT_BITS : STEP_W;
    // marks run a little past the count, two extra bits keep them from wrapping
    localparam int MW = NW + 2;

    t_coord        r_x, r_y, r_z;
    logic [NW-1:0] r_rem;       // steps left
    logic [NW-1:0] r_idx;       // index of the step being taken, from 1
    logic [MW-1:0] r_run;
    logic [MW-1:0] r_turn_mark;
    logic [MW-1:0] r_sign_mark;
    logic          r_axis_x;    // 1: moving along X, 0: along Z
    logic          r_neg;       // moving in the minus direction

    logic [MW-1:0]        idx_ext;
    logic                 hit_sign, hit_turn;
    logic [MW-1:0]        n_run;
    logic signed [COORD_W:0] mv_src, mv_sum;
    t_coord               mv_sat;

    assign idx_ext  = MW'(r_idx);
    assign hit_sign = (idx_ext == r_sign_mark);
    assign hit_turn = (idx_ext == r_turn_mark);
    assign n_run    = hit_sign ? r_run + MW'(1) : r_run;

    // saturating move of the active coordinate
    always_comb begin
        mv_src = r_axis_x ? {r_x[COORD_W-1], r_x} : {r_z[COORD_W-1], r_z};
        mv_sum = r_neg ? mv_src - UNIT_STEP : mv_src + UNIT_STEP;
        if (mv_sum > COORD_MAX)      mv_sat = COORD_MAX[COORD_W-1:0];
        else if (mv_sum < COORD_MIN) mv_sat = COORD_MIN[COORD_W-1:0];
        else                         mv_sat = mv_sum[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x         <= i_start_x;
            r_y         <= i_start_y;
            r_z         <= i_start_z;
            r_rem       <= i_step_count[NW-1:0];
            r_idx       <= NW'(1);
            r_run       <= MW'(1);
            r_turn_mark <= MW'(1);
            r_sign_mark <= MW'(2);
            r_axis_x    <= 1'b0;
            r_neg       <= 1'b0;
        end else if (i_cmd.step) begin
            if (r_axis_x) r_x <= mv_sat;
            else          r_z <= mv_sat;
            r_rem       <= r_rem - NW'(1);
            r_idx       <= r_idx + NW'(1);
            r_run       <= n_run;
            r_neg       <= r_neg ^ hit_sign;
            r_axis_x    <= r_axis_x ^ hit_turn;
            if (hit_sign) r_sign_mark <= r_sign_mark + {n_run[MW-2:0], 1'b0};
            if (hit_turn) r_turn_mark <= r_turn_mark + n_run;
        end
    end

    assign o_sts.done = (r_rem == '0);
    assign o_pos_x    = r_x;
    assign o_pos_y    = r_y;
    assign o_pos_z    = r_z;

endmodule

@@ sv/square_spiral_position_core.sv @@
// ----------------------------------------------------------------------------
// square_spiral_position_core: point reached along a square spiral
// Walks step_count unit steps from a start point in the X-Z plane.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  request channel (valid/ready): start_x/y/z in signed 16.8 fixed
//          point and step_count. Only the low COUNT_BITS bits (at most
//          STEP_W) of the count are used.
//   o_res  result channel (valid/ready): pos_x/pos_z saturated, pos_y equal
//          to start_y. One result per request, in request order.
//   Timing: one request in flight at a time. A request is taken in the idle
//   state, then one spiral step per cycle in the datapath's single saturating
//   adder; the result is offered once the step count runs out.
//   Stall: the result stays on o_res with valid high until ready; no new
//   request is taken until it is delivered.
//   Reset: i_rst_n is synchronous, active low; the controller returns to idle,
//   any request in flight is dropped and o_res.valid goes low.
// ----------------------------------------------------------------------------
module square_spiral_position_core import ssp_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssp_in_if.sink    i_req,
    ssp_out_if.source o_res
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: idle -> stepping -> holding result
    ssp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // walk datapath; position registers double as the result register
    ssp_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_start_x    (i_req.start_x),
        .i_start_y    (i_req.start_y),
        .i_start_z    (i_req.start_z),
        .i_step_count (i_req.step_count),
        .o_sts        (sts),
        .o_pos_x      (o_res.pos_x),
        .o_pos_y      (o_res.pos_y),
        .o_pos_z      (o_res.pos_z)
    );

    // taking a request and offering a result never overlap
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_res.valid))
        else $error("request taken while a result is pending");

    // once a request is taken, the next one waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request taken during a walk");

    // a delivered result is gone the next cycle
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready) |=> !o_res.valid)
        else $error("result repeated");

    // Y is not touched by the walk
    a_y_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_req.ready && $past(!i_req.ready)) |-> $stable(o_res.pos_y))
        else $error("Y moved during a walk");

endmodule
